// ===== rtl/core/csm_pkg.sv =====
// Shared types and constants for the CSR sparse matrix-vector core.
package csm_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 65536;
  localparam int COL_W      = 10;
  localparam int NCOLS_W    = 11;
  localparam int NROWS_W    = 17;
  localparam int ROW_W      = 16;
  localparam int VAL_W      = 32;
  localparam int SUM_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [NCOLS_W-1:0] NCOLS_RST = NCOLS_W'(MAX_COLS);
  localparam logic [NROWS_W-1:0] NROWS_RST = NROWS_W'(MAX_ROWS);

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_ENTRY = 2'd1,
    REQ_ROW   = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_COLS = 2'd0,
    CFG_NUM_ROWS = 2'd1
  } cfg_index_t;

  // Pipeline control carried with each word.
  typedef struct packed {
    logic valid;
    logic is_row;  // row end; otherwise an entry
    logic col_ok;  // entry column inside the column count
  } stage_ctl_t;

endpackage

// ===== rtl/core/csm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module csm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/csr_sparse_matvec_core.sv =====
// Top level of the CSR sparse matrix times dense vector core.
// Usage: input words (in_*) come in three kinds. A load writes in_value
//   into the vector store at in_column. An entry multiplies in_value
//   (Q16.16) by the stored element of its column and adds the Q32.32
//   product into the row sum, saturating at the signed 64-bit limits. A
//   row end emits one result word (out_*) with row index, row sum,
//   last_row and column_error, then clears the sum and error flag.
//   Entries at or beyond num_cols are dropped and flag column_error on
//   their row; unused request codes are dropped. Config (cfg_*) sets
//   num_cols (index 0) and num_rows (index 1); write only while idle.
//   cfg_ready is always high.
// Timing: three stages (vector read, 32x32 multiply, accumulate into the
//   output register); a row end goes through all three before out_*.
//   One word is accepted every cycle while no stall holds the pipeline.
// Stall: the whole pipeline holds while a result waits and out_ready is
//   low; in_ready then drops. A result taken in the same cycle does not
//   block intake.
// Reset: rst_n (sync, active low) clears pipeline valids, row sum, row
//   counter, error flag and sets num_cols=1024, num_rows=65536. The
//   vector store is not cleared; load it before use.
module csr_sparse_matvec_core
  import csm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_req_type,
  input  logic [COL_W-1:0]      in_column,
  input  logic signed [VAL_W-1:0] in_value,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ROW_W-1:0]      out_row_index,
  output logic signed [SUM_W-1:0] out_row_sum,
  output logic                  out_last_row,
  output logic                  out_column_error,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [NCOLS_W-1:0] num_cols_r;
  logic [NROWS_W-1:0] num_rows_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r <= NCOLS_RST;
      num_rows_r <= NROWS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NUM_COLS: num_cols_r <= cfg_data[NCOLS_W-1:0];
        CFG_NUM_ROWS: num_rows_r <= cfg_data[NROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Last row index: 0 or anything past 65536 counts as 65536 rows.
  logic               rows_full;
  logic [NROWS_W-1:0] last_idx;

  assign rows_full = (num_rows_r == '0) ||
                     (num_rows_r[NROWS_W-1] && (num_rows_r[NROWS_W-2:0] != '0));
  assign last_idx  = (rows_full ? NROWS_RST : num_rows_r) - NROWS_W'(1);

  // ---------------------------------------------------------------
  // Pipeline advance: everything moves when the output slot is free
  // or is being emptied this cycle.
  // ---------------------------------------------------------------
  logic advance;
  logic in_fire;
  logic out_valid_r;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;
  assign in_fire  = in_valid && in_ready;

  // ---------------------------------------------------------------
  // Stage 0: decode, vector store write/read
  // ---------------------------------------------------------------
  req_type_t  req;
  stage_ctl_t s0_ctl;
  logic       ld_we;

  assign req   = req_type_t'(in_req_type);
  assign ld_we = in_fire && (req == REQ_LOAD);

  always_comb begin
    s0_ctl.valid  = in_fire && ((req == REQ_ENTRY) || (req == REQ_ROW));
    s0_ctl.is_row = (req == REQ_ROW);
    s0_ctl.col_ok = ({1'b0, in_column} < num_cols_r);
  end

  logic [VAL_W-1:0] vec_rdata;

  csm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_COLS)
  ) u_vec_ram (
    .clk   (clk),
    .we    (ld_we),
    .waddr (in_column),
    .wdata (in_value),
    .re    (advance),
    .raddr (in_column),
    .rdata (vec_rdata)
  );

  // ---------------------------------------------------------------
  // Stage 1: coefficient held beside the store read data
  // ---------------------------------------------------------------
  stage_ctl_t            s1_ctl_r;
  logic signed [VAL_W-1:0] s1_coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else if (advance) begin
      s1_ctl_r <= s0_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_coef_r <= in_value;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: exact Q32.32 product
  // ---------------------------------------------------------------
  stage_ctl_t              s2_ctl_r;
  logic signed [SUM_W-1:0] s2_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else if (advance) begin
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_prod_r <= SUM_W'(s1_coef_r) * SUM_W'($signed(vec_rdata));
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: saturating accumulate, row end into output register
  // ---------------------------------------------------------------
  logic signed [SUM_W-1:0] acc_r, acc_nxt;
  logic                    err_r;
  logic [ROW_W-1:0]        row_cnt_r;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;
  logic                    row_last;
  logic                    row_emit;

  assign sum_wide = {acc_r[SUM_W-1], acc_r} + {s2_prod_r[SUM_W-1], s2_prod_r};

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  assign row_emit = advance && s2_ctl_r.valid && s2_ctl_r.is_row;
  // Counter at or past the last index (possible after a row count change).
  assign row_last = ({1'b0, row_cnt_r} >= last_idx);

  always_comb begin
    acc_nxt = acc_r;
    if (advance && s2_ctl_r.valid) begin
      if (s2_ctl_r.is_row) begin
        acc_nxt = '0;
      end else if (s2_ctl_r.col_ok) begin
        acc_nxt = sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      err_r     <= 1'b0;
      row_cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      if (row_emit) begin
        err_r     <= 1'b0;
        row_cnt_r <= row_last ? '0 : row_cnt_r + ROW_W'(1);
      end else if (advance && s2_ctl_r.valid && !s2_ctl_r.col_ok) begin
        err_r <= 1'b1;
      end
    end
  end

  // Output register
  logic [ROW_W-1:0]        out_row_r;
  logic signed [SUM_W-1:0] out_sum_r;
  logic                    out_last_r;
  logic                    out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (row_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_emit) begin
      out_row_r  <= row_cnt_r;
      out_sum_r  <= acc_r;
      out_last_r <= row_last;
      out_err_r  <= err_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row_index    = out_row_r;
  assign out_row_sum      = out_sum_r;
  assign out_last_row     = out_last_r;
  assign out_column_error = out_err_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_row_clears_sum : assert property (@(posedge clk) disable iff (!rst_n)
    row_emit |=> (acc_r == '0) && !err_r)
    else $error("row sum or error flag not cleared after row end");

  a_last_wraps : assert property (@(posedge clk) disable iff (!rst_n)
    (row_emit && row_last) |=> (row_cnt_r == '0) && out_last_row)
    else $error("row counter did not wrap after last row");

  a_bad_col_flags : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s2_ctl_r.valid && !s2_ctl_r.is_row && !s2_ctl_r.col_ok)
      |=> err_r && $stable(acc_r))
    else $error("out-of-range column changed sum or missed error flag");

  a_stall_only_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid_r && !out_ready)
    else $error("intake stalled without a blocked result");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for csr_sparse_matvec_core: directed script, then random phases.
module tb;
  import csm_pkg::*;

  // Result words seen on out_*; packed so a whole row compares and clears at once.
  typedef struct packed {
    logic [ROW_W-1:0]        idx;
    logic signed [SUM_W-1:0] sum;
    logic                    last;
    logic                    err;
  } row_result_t;

  // One line of the directed script: either a config write or an input word.
  // Row ends with "typed" set carry their expected result inline.
  typedef struct {
    bit                    is_cfg;
    cfg_index_t            reg_sel;
    logic [CFG_DATA_W-1:0] reg_data;
    req_type_t             kind;
    logic [COL_W-1:0]      column;
    logic [VAL_W-1:0]      value;
    bit                    typed;
    row_result_t           want;
  } script_row_t;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PIPE_DRAIN    = 8;    // three stages plus margin
  localparam int RAND_PHASES   = 10;
  localparam int PHASE_WORDS   = 85;   // loads, entries and row ends per phase

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_req_type = REQ_NONE;
  logic [COL_W-1:0]        in_column = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [ROW_W-1:0]        out_row_index;
  logic signed [SUM_W-1:0] out_row_sum;
  logic                    out_last_row;
  logic                    out_column_error;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_NUM_COLS;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  // Mirror of the core: vector store, row accumulator, row counter, error flag, config.
  logic signed [VAL_W-1:0] vec_mirror [MAX_COLS];
  bit                      vec_loaded [MAX_COLS];
  int unsigned             loaded_cols [$];   // columns safe to read as entries
  logic signed [SUM_W-1:0] row_acc = '0;
  logic [ROW_W-1:0]        row_ctr = '0;
  bit                      row_err = 1'b0;
  logic [NCOLS_W-1:0]      cols_reg = NCOLS_RST;
  logic [NROWS_W-1:0]      rows_reg = NROWS_RST;

  row_result_t             pending_rows [$];  // rows owed by the core, oldest first
  script_row_t             script [$];
  int                      mismatches = 0;
  int                      cycle_count = 0;
  int                      burst_left = 0;

  csr_sparse_matvec_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_column        (in_column),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_row_index    (out_row_index),
    .out_row_sum      (out_row_sum),
    .out_last_row     (out_last_row),
    .out_column_error (out_column_error),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost row ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d rows still owed", cycle_count, pending_rows.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h (cycle %0d)", what, got, want, cycle_count);
    mismatches++;
  endtask

  // Advance the mirror by one accepted word. Returns 1 on a row end, with the
  // row result the core owes for it.
  function automatic bit advance_matvec(input req_type_t kind, input logic [COL_W-1:0] col,
                                        input logic signed [VAL_W-1:0] val,
                                        output row_result_t res);
    int unsigned             eff_cols;
    int unsigned             eff_rows;
    logic signed [SUM_W-1:0] prod;
    logic signed [SUM_W:0]   total;
    bit                      at_end;
    res = '0;
    eff_cols = (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
    eff_rows = (rows_reg == 0 || rows_reg > 65536) ? 65536 : rows_reg;
    if (eff_rows > MAX_ROWS) eff_rows = MAX_ROWS;
    case (kind)
      REQ_LOAD: begin
        // Loads are never checked against num_cols.
        vec_mirror[col] = val;
        if (!vec_loaded[col]) begin
          vec_loaded[col] = 1'b1;
          loaded_cols = {loaded_cols, int'(unsigned'(col))};
        end
      end
      REQ_ENTRY: begin
        if (col < eff_cols) begin
          // Q16.16 x Q16.16 is exact in Q32.32; the add clamps on overflow.
          prod  = val * vec_mirror[col];
          total = row_acc + prod;
          if (total[SUM_W] != total[SUM_W-1]) row_acc = total[SUM_W] ? SUM_MIN : SUM_MAX;
          else row_acc = total[SUM_W-1:0];
        end else begin
          row_err = 1'b1;
        end
      end
      REQ_ROW: begin
        // A counter left past the end by a config change also counts as last.
        at_end   = (32'(row_ctr) >= eff_rows - 1);
        res.idx  = row_ctr;
        res.sum  = row_acc;
        res.last = at_end;
        res.err  = row_err;
        row_ctr  = at_end ? '0 : row_ctr + 16'd1;
        row_acc  = '0;
        row_err  = 1'b0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  // The sender runs in bursts with random gaps in between.
  task automatic drive_word(input req_type_t kind, input logic [COL_W-1:0] col,
                            input logic [VAL_W-1:0] val, input bit typed,
                            input row_result_t want);
    int          gap;
    bit          has_row;
    row_result_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_column   <= col;
    in_value    <= val;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    has_row = advance_matvec(kind, col, val, predicted);
    if (typed) predicted = want;
    if (has_row) pending_rows = {pending_rows, predicted};
    @(negedge clk);
  endtask

  // Drop valid, let every owed row come back, then let trailing loads and
  // entries drain from the pipe before any register write.
  task automatic settle_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes keep it up; caller lowers it.
  task automatic write_reg(input cfg_index_t sel, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    if (sel == CFG_NUM_COLS) cols_reg = data[NCOLS_W-1:0];
    else if (sel == CFG_NUM_ROWS) rows_reg = data;
    @(negedge clk);
  endtask

  function automatic void add_word(input req_type_t kind, input logic [COL_W-1:0] col,
                                   input logic [VAL_W-1:0] val);
    script_row_t row;
    row = '{1'b0, CFG_NUM_COLS, '0, kind, col, val, 1'b0, '0};
    script = {script, row};
  endfunction

  function automatic void add_row_check(input logic [ROW_W-1:0] idx,
                                        input logic [SUM_W-1:0] sum,
                                        input logic last, input logic err);
    script_row_t row;
    row = '{1'b0, CFG_NUM_COLS, '0, REQ_ROW, '0, '0, 1'b1,
            row_result_t'{idx, sum, last, err}};
    script = {script, row};
  endfunction

  function automatic void add_cfg(input cfg_index_t sel, input logic [CFG_DATA_W-1:0] data);
    script_row_t row;
    row = '{1'b1, sel, data, REQ_NONE, '0, '0, 1'b0, '0};
    script = {script, row};
  endfunction

  // Mostly full-range random, with the Q16.16 extremes and small magnitudes mixed in.
  function automatic logic [VAL_W-1:0] sample_q16();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: cycles through always-ready, 3-of-4, coin-flip and long-stall patterns.
  always @(negedge clk) begin
    case ((cycle_count / 160) % 4)
      0:       out_ready <= 1'b1;
      1:       out_ready <= (cycle_count % 4) != 3;
      2:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= (cycle_count % 16) >= 12;
    endcase
  end

  // Every taken row word is matched against the oldest owed row.
  always @(posedge clk) begin
    row_result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_rows.size() == 0) begin
        flag_mismatch("row word with nothing owed, row_index", out_row_index, '0);
      end else begin
        want = pending_rows.pop_front();
        if (out_row_index !== want.idx)
          flag_mismatch("row_index", out_row_index, want.idx);
        if (out_row_sum !== want.sum)
          flag_mismatch($sformatf("row_sum of row %0d", want.idx), out_row_sum, want.sum);
        if (out_last_row !== want.last)
          flag_mismatch($sformatf("last_row of row %0d", want.idx), out_last_row, want.last);
        if (out_column_error !== want.err)
          flag_mismatch($sformatf("column_error of row %0d", want.idx),
                        out_column_error, want.err);
      end
    end
  end

  initial begin
    req_type_t             kind;
    logic [COL_W-1:0]      col;
    logic [CFG_DATA_W-1:0] cols_pick;
    logic [CFG_DATA_W-1:0] rows_pick;
    int unsigned           eff;
    int unsigned           pick;
    int                    counted;
    int                    roll;
    bit                    found;

    foreach (vec_loaded[i]) vec_loaded[i] = 1'b0;

    // Directed script, default config first (1024 columns, 65536 rows).
    // Empty row straight after reset must read zero.
    add_row_check(16'd0, '0, 1'b0, 1'b0);
    add_word(REQ_LOAD, 10'd0, 32'h7FFF_FFFF);
    add_word(REQ_LOAD, 10'd1023, 32'h8000_0000);
    add_word(REQ_LOAD, 10'd5, 32'h0001_0000);          // 1.0
    add_word(REQ_ENTRY, 10'd5, 32'h0002_0000);         // 2.0 x 1.0
    add_row_check(16'd1, 64'sh0000_0002_0000_0000, 1'b0, 1'b0);
    // Three near-2^62 products clamp high, then three negative ones clamp low.
    repeat (3) add_word(REQ_ENTRY, 10'd0, 32'h7FFF_FFFF);
    add_row_check(16'd2, SUM_MAX, 1'b0, 1'b0);
    repeat (3) add_word(REQ_ENTRY, 10'd1023, 32'h7FFF_FFFF);
    add_row_check(16'd3, SUM_MIN, 1'b0, 1'b0);
    // Clamp high, then step back down from the clamped value.
    repeat (3) add_word(REQ_ENTRY, 10'd0, 32'h7FFF_FFFF);
    add_word(REQ_ENTRY, 10'd1023, 32'h7FFF_FFFF);
    add_word(REQ_NONE, 10'd1023, 32'hFFFF_FFFF);       // unused code, dropped
    add_word(REQ_ROW, '0, '0);
    // Column beyond the count: not summed, flagged on the row.
    add_cfg(CFG_NUM_COLS, 17'd3);
    add_word(REQ_ENTRY, 10'd5, 32'h0000_1234);
    add_row_check(16'd5, '0, 1'b0, 1'b1);
    // Shrinking the row count below the counter forces last_row and a wrap.
    add_cfg(CFG_NUM_ROWS, 17'd2);
    add_row_check(16'd6, '0, 1'b1, 1'b0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle_idle();
        write_reg(script[i].reg_sel, script[i].reg_data);
        cfg_valid <= 1'b0;
      end else begin
        drive_word(script[i].kind, script[i].column, script[i].value,
                   script[i].typed, script[i].want);
      end
    end

    // Random phases, each under its own config; extremes in the early ones.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0:       begin cols_pick = 17'd1024; rows_pick = 17'd65536;  end
        1:       begin cols_pick = 17'd1;    rows_pick = 17'd1;      end
        2:       begin cols_pick = 17'd2047; rows_pick = 17'd131071; end  // both clamp
        3:       begin cols_pick = 17'd0;    rows_pick = 17'd0;      end  // no column valid
        4:       begin cols_pick = 17'd512;  rows_pick = 17'($urandom_range(2, 8)); end
        5:       begin cols_pick = 17'd3;    rows_pick = 17'd2;      end
        6:       begin cols_pick = 17'd1024; rows_pick = 17'd3;      end
        default: begin
          cols_pick = 17'($urandom_range(1, 1024));
          rows_pick = 17'($urandom_range(1, 40));
        end
      endcase
      settle_idle();
      write_reg(CFG_NUM_COLS, cols_pick);
      write_reg(CFG_NUM_ROWS, rows_pick);
      cfg_valid <= 1'b0;

      counted = 0;
      while (counted < PHASE_WORDS) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          // Noise: the unused code, not counted.
          drive_word(REQ_NONE, 10'($urandom), $urandom, 1'b0, '0);
        end else begin
          kind = (roll < 18) ? REQ_LOAD : (roll < 75) ? REQ_ENTRY : REQ_ROW;
          col  = 10'($urandom_range(0, MAX_COLS - 1));
          if (kind == REQ_ENTRY) begin
            eff = (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
            if (eff == 0 || (eff < MAX_COLS && $urandom_range(0, 9) == 0)) begin
              col = 10'($urandom_range(eff, MAX_COLS - 1));
            end else begin
              // In-range entries only read columns already loaded; if none
              // turns up, load one instead.
              found = 1'b0;
              repeat (8) begin
                pick = loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
                if (!found && pick < eff) begin
                  col   = 10'(pick);
                  found = 1'b1;
                end
              end
              if (!found) begin
                kind = REQ_LOAD;
                col  = 10'($urandom_range(0, eff - 1));
              end
            end
          end
          drive_word(kind, col, (kind == REQ_ROW) ? 32'($urandom) : sample_q16(), 1'b0, '0);
          counted++;
        end
      end
    end

    settle_idle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
